// ----- hw/rtl/cfe_pkg.sv -----
package cfe_pkg;

    localparam int MAX_IN_CH  = 16;
    localparam int MAX_OUT_CH = 16;
    localparam int MAX_KERNEL = 7;
    localparam int MAX_DIM    = 32;

    localparam int PIX_DEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);
    localparam int BIAS_AW   = $clog2(MAX_OUT_CH);
    localparam int ACC_W     = 41;

    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_BIAS    = 2'd1,
        OP_PIXEL   = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_IN_CH   = 3'd0,
        REG_OUT_CH  = 3'd1,
        REG_K_ROWS  = 3'd2,
        REG_K_COLS  = 3'd3,
        REG_STEP    = 3'd4,
        REG_PAD     = 3'd5,
        REG_IN_H    = 3'd6,
        REG_IN_W    = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // control from sequencer to MAC unit
    typedef struct packed {
        logic clear;
        logic acc_en;
        logic finish;
    } mac_ctl_t;

endpackage

// ----- hw/rtl/cfe_ram.sv -----
module cfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/cfe_mac.sv -----
module cfe_mac
    import cfe_pkg::*;
(
    input  logic               clk,
    input  mac_ctl_t           ctl,
    input  logic signed [15:0] bias,
    input  logic signed [15:0] wgt,
    input  logic signed [15:0] pix,
    output logic signed [15:0] result_q,
    output logic               sat_q
);

    logic signed [31:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-9:0] shifted;
    logic signed [15:0]    result_reg;
    logic                  sat_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = ACC_W'(bias) <<< 8;
        end
        else if (ctl.acc_en)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    assign shifted = acc_reg[ACC_W-1:8];

    always_ff @(posedge clk)
    begin
        prod_reg <= wgt * pix;
        acc_reg  <= acc_next;
        if (ctl.finish)
        begin
            if (shifted > (ACC_W-8)'(32767))
            begin
                result_reg <= 16'sh7fff;
                sat_reg    <= 1'b1;
            end
            else if (shifted < -(ACC_W-8)'(32768))
            begin
                result_reg <= 16'sh8000;
                sat_reg    <= 1'b1;
            end
            else
            begin
                result_reg <= shifted[15:0];
                sat_reg    <= 1'b0;
            end
        end
    end

    assign result_q = result_reg;
    assign sat_q    = sat_reg;

endmodule

// ----- hw/rtl/conv2d_forward_engine_core.sv -----
// Load items (weight, bias, pixel) are taken while idle; busy stays low.
// Compute: busy from start to result; it scans in_channels*kernel_rows*kernel_cols taps
// after clamping (none for an empty sum), one tap per cycle through the single shared MAC.
// Result strobe in the last busy cycle; no new item is taken while busy.
// Bad coordinates: no scan; the strobe comes with busy. Results cannot be stalled.
// Reset clears registers to defaults and the sequencer; stores are unset.
module conv2d_forward_engine_core
    import cfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [3:0]         out_chan,
    input  logic [3:0]         in_chan,
    input  logic [4:0]         row,
    input  logic [4:0]         col,
    input  logic [2:0]         tap_row,
    input  logic [2:0]         tap_col,
    input  logic signed [15:0] value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    output logic               result_strobe,
    output logic signed [15:0] result_value,
    output logic               saturated,
    output logic               coord_error
);

    logic [4:0] in_ch_reg, out_ch_reg;
    logic [2:0] k_rows_reg, k_cols_reg, step_reg;
    logic [1:0] pad_reg;
    logic [5:0] in_h_reg, in_w_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg  <= 5'd1;
            out_ch_reg <= 5'd1;
            k_rows_reg <= 3'd3;
            k_cols_reg <= 3'd3;
            step_reg   <= 3'd1;
            pad_reg    <= 2'd0;
            in_h_reg   <= 6'd32;
            in_w_reg   <= 6'd32;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_IN_CH:  in_ch_reg  <= cfg_data[4:0];
                REG_OUT_CH: out_ch_reg <= cfg_data[4:0];
                REG_K_ROWS: k_rows_reg <= cfg_data[2:0];
                REG_K_COLS: k_cols_reg <= cfg_data[2:0];
                REG_STEP:   step_reg   <= cfg_data[2:0];
                REG_PAD:    pad_reg    <= cfg_data[1:0];
                REG_IN_H:   in_h_reg   <= cfg_data;
                REG_IN_W:   in_w_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // effective (clamped) configuration
    logic [4:0] nic, noc;
    logic [2:0] kr, kc, s;
    logic [5:0] h, w;
    logic signed [8:0] span_h, span_w;
    logic [5:0] oh, ow;

    assign nic = (in_ch_reg > 5'd16) ? 5'd16 : in_ch_reg;
    assign noc = (out_ch_reg > 5'd16) ? 5'd16 : out_ch_reg;
    assign kr  = (k_rows_reg > 3'd7) ? 3'd7 : k_rows_reg;
    assign kc  = (k_cols_reg > 3'd7) ? 3'd7 : k_cols_reg;
    assign s   = (step_reg == 3'd0) ? 3'd1 : step_reg;
    assign h   = (in_h_reg > 6'd32) ? 6'd32 : in_h_reg;
    assign w   = (in_w_reg > 6'd32) ? 6'd32 : in_w_reg;
    assign span_h = 9'(h) + 9'({pad_reg, 1'b0}) - 9'(kr);
    assign span_w = 9'(w) + 9'({pad_reg, 1'b0}) - 9'(kc);

    // span <= 38, s <= 7: small division via case on stride
    function automatic logic [5:0] osz(input logic signed [8:0] sp, input logic [2:0] st);
        logic [5:0] u;
        logic [5:0] q;
        begin
            u = sp[5:0];
            case (st)
                3'd2:    q = u >> 1;
                3'd3:    q = 6'((12'(u) * 12'd43) >> 7);
                3'd4:    q = u >> 2;
                3'd5:    q = 6'((12'(u) * 12'd52) >> 8);
                3'd6:    q = 6'((12'(u) * 12'd43) >> 8);
                3'd7:    q = 6'((12'(u) * 12'd37) >> 8);
                default: q = u;
            endcase
            osz = sp[8] ? 6'd0 : 6'(q + 6'd1);
        end
    endfunction

    assign oh = osz(span_h, s);
    assign ow = osz(span_w, s);

    state_t state_reg, state_next;

    logic [3:0] oc_reg;
    logic [4:0] r_reg, c_reg;
    logic [4:0] ch_reg, ch_next;
    logic [2:0] a_reg, a_next, b_reg, b_next;
    logic       bad_reg;
    logic [1:0] drain_reg;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    logic bad_now;
    assign bad_now = ({1'b0, out_chan} >= noc) || ({1'b0, row} >= oh) || ({1'b0, col} >= ow);

    logic scan_last;
    assign scan_last = (b_reg == kc - 3'd1) && (a_reg == kr - 3'd1) && (ch_reg == nic - 5'd1);
    logic empty_sum;
    assign empty_sum = (nic == 5'd0) || (kr == 3'd0) || (kc == 3'd0);

    // tap coordinates
    logic signed [8:0] y, x;
    logic tap_ok;
    assign y = 9'(r_reg) * 9'(s) + 9'(a_reg) - 9'(pad_reg);
    assign x = 9'(c_reg) * 9'(s) + 9'(b_reg) - 9'(pad_reg);
    assign tap_ok = (state_reg == ST_SCAN) && !y[8] && !x[8] &&
                    (y[5:0] < h) && (x[5:0] < w);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && op_t'(operation) == OP_COMPUTE)
                begin
                    state_next = bad_now ? ST_DONE : ST_BIAS;
                end
            ST_BIAS:  state_next = empty_sum ? ST_DRAIN : ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_reg == 2'd3) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ch_next = ch_reg;
        a_next  = a_reg;
        b_next  = b_reg;
        if (state_reg == ST_BIAS)
        begin
            ch_next = '0;
            a_next  = '0;
            b_next  = '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (b_reg == kc - 3'd1)
            begin
                b_next = '0;
                if (a_reg == kr - 3'd1)
                begin
                    a_next  = '0;
                    ch_next = ch_reg + 5'd1;
                end
                else
                begin
                    a_next = a_reg + 3'd1;
                end
            end
            else
            begin
                b_next = b_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= (state_reg == ST_DRAIN) ? drain_reg + 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        if (accept)
        begin
            oc_reg  <= out_chan;
            r_reg   <= row;
            c_reg   <= col;
            bad_reg <= bad_now;
        end
    end

    // memories
    logic we_w, we_p, we_b;
    logic [WGT_AW-1:0]  w_waddr, w_raddr;
    logic [PIX_AW-1:0]  p_waddr, p_raddr;
    logic signed [15:0] w_rdata, p_rdata, b_rdata;

    assign we_w = accept && op_t'(operation) == OP_WEIGHT &&
                  tap_row < 3'd7 && tap_col < 3'd7;
    assign we_b = accept && op_t'(operation) == OP_BIAS;
    assign we_p = accept && op_t'(operation) == OP_PIXEL;

    assign w_waddr = WGT_AW'(((({out_chan, in_chan}) * 7 + tap_row) * 7) + tap_col);
    assign w_raddr = WGT_AW'(((({oc_reg, ch_reg[3:0]}) * 7 + a_reg) * 7) + b_reg);
    assign p_waddr = {in_chan, row, col};
    assign p_raddr = {ch_reg[3:0], y[4:0], x[4:0]};

    cfe_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt (
        .clk(clk), .we(we_w), .waddr(w_waddr), .wdata(value),
        .raddr(w_raddr), .rdata(w_rdata)
    );
    cfe_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH)) u_pix (
        .clk(clk), .we(we_p), .waddr(p_waddr), .wdata(value),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    cfe_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CH)) u_bias (
        .clk(clk), .we(we_b), .waddr(out_chan), .wdata(value),
        .raddr(oc_reg), .rdata(b_rdata)
    );

    // ok flag delayed to line up with RAM data (ok_d1) and product (ok_d2)
    logic ok_d1_reg, ok_d2_reg, bias_d1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_d1_reg   <= 1'b0;
            ok_d2_reg   <= 1'b0;
            bias_d1_reg <= 1'b0;
        end
        else
        begin
            ok_d1_reg   <= tap_ok;
            ok_d2_reg   <= ok_d1_reg;
            bias_d1_reg <= (state_reg == ST_BIAS);
        end
    end

    mac_ctl_t ctl;
    assign ctl.clear  = bias_d1_reg;
    assign ctl.acc_en = ok_d2_reg;
    assign ctl.finish = (state_reg == ST_DRAIN) && (drain_reg == 2'd3);

    logic signed [15:0] mac_q;
    logic               mac_sat;

    cfe_mac u_mac (
        .clk(clk), .ctl(ctl), .bias(b_rdata), .wgt(w_rdata), .pix(p_rdata),
        .result_q(mac_q), .sat_q(mac_sat)
    );

    assign result_strobe = (state_reg == ST_DONE);
    assign result_value  = bad_reg ? 16'sd0 : mac_q;
    assign saturated     = bad_reg ? 1'b0 : mac_sat;
    assign coord_error   = bad_reg;

endmodule

// ----- bench/tb_conv2d_forward_engine_core.sv -----
`timescale 1ns / 100ps

module tb_conv2d_forward_engine_core;
    import cfe_pkg::*;

    class conv_scoreboard;
        logic signed [15:0] pix [PIX_DEPTH];
        logic signed [15:0] wgt [WGT_DEPTH];
        logic signed [15:0] bias [MAX_OUT_CH];
        int unsigned n_ic, n_oc, k_r, k_c, stride, pad, ih, iw;
        logic [17:0] pending [$];
        int errors;

        function void init();
            n_ic = 1; n_oc = 1; k_r = 3; k_c = 3; stride = 1; pad = 0; ih = 32; iw = 32;
            errors = 0;
            foreach (bias[i]) bias[i] = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [5:0] d);
            case (idx)
                REG_IN_CH:  n_ic = d[4:0];
                REG_OUT_CH: n_oc = d[4:0];
                REG_K_ROWS: k_r = d[2:0];
                REG_K_COLS: k_c = d[2:0];
                REG_STEP:   stride = d[2:0];
                REG_PAD:    pad = d[1:0];
                REG_IN_H:   ih = d;
                default:    iw = d;
            endcase
        endfunction

        function int osize(int n, int p, int k, int s);
            int span;
            span = n + 2 * p - k;
            if (span < 0) return 0;
            return span / s + 1;
        endfunction

        function void note_item(op_t op, int oc, int ic, int r, int c, int tr, int tc,
                                logic signed [15:0] v);
            int nic, noc, kr, kc, s, h, w, oh, ow, y, x;
            longint acc, q;
            logic sat;
            case (op)
                OP_WEIGHT:
                    if (tr < MAX_KERNEL && tc < MAX_KERNEL)
                        wgt[((oc * MAX_IN_CH + ic) * MAX_KERNEL + tr) * MAX_KERNEL + tc] = v;
                OP_BIAS:  bias[oc] = v;
                OP_PIXEL: pix[(ic * MAX_DIM + r) * MAX_DIM + c] = v;
                default:
                begin
                    nic = n_ic > MAX_IN_CH ? MAX_IN_CH : n_ic;
                    noc = n_oc > MAX_OUT_CH ? MAX_OUT_CH : n_oc;
                    kr = k_r > MAX_KERNEL ? MAX_KERNEL : k_r;
                    kc = k_c > MAX_KERNEL ? MAX_KERNEL : k_c;
                    s = stride == 0 ? 1 : stride;
                    h = ih > MAX_DIM ? MAX_DIM : ih;
                    w = iw > MAX_DIM ? MAX_DIM : iw;
                    oh = osize(h, pad, kr, s);
                    ow = osize(w, pad, kc, s);
                    if (oc >= noc || r >= oh || c >= ow)
                    begin
                        pending.push_back({16'sd0, 1'b0, 1'b1});
                        return;
                    end
                    acc = longint'(bias[oc]) * 256;
                    for (int ch = 0; ch < nic; ch++)
                        for (int a = 0; a < kr; a++)
                        begin
                            y = r * s + a - pad;
                            if (y < 0 || y >= h) continue;
                            for (int b = 0; b < kc; b++)
                            begin
                                x = c * s + b - pad;
                                if (x < 0 || x >= w) continue;
                                acc += longint'(wgt[((oc * MAX_IN_CH + ch) * MAX_KERNEL + a)
                                       * MAX_KERNEL + b]) * longint'(pix[(ch * MAX_DIM + y)
                                       * MAX_DIM + x]);
                            end
                        end
                    q = acc >>> 8;
                    sat = 0;
                    if (q > 32767) begin q = 32767; sat = 1; end
                    else if (q < -32768) begin q = -32768; sat = 1; end
                    pending.push_back({q[15:0], sat, 1'b0});
                end
            endcase
        endfunction

        function void check_result(logic [15:0] rv, logic sat, logic ce);
            logic [17:0] e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %h %b %b", $time, rv, sat, ce);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e[17:2] !== rv)
            begin
                $display("%0t result_value exp %h act %h", $time, e[17:2], rv);
                errors++;
            end
            if (e[1] !== sat)
            begin
                $display("%0t saturated exp %b act %b", $time, e[1], sat);
                errors++;
            end
            if (e[0] !== ce)
            begin
                $display("%0t coord_error exp %b act %b", $time, e[0], ce);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0, start = 0, cfg_valid = 0;
    logic busy, cfg_ready, result_strobe, saturated, coord_error;
    logic [1:0] operation = 0;
    logic [3:0] out_chan = 0, in_chan = 0;
    logic [4:0] row = 0, col = 0;
    logic [2:0] tap_row = 0, tap_col = 0, cfg_index = 0;
    logic signed [15:0] value = 0, result_value;
    logic [5:0] cfg_data = 0;
    bit quiet = 0;

    conv_scoreboard sb;

    conv2d_forward_engine_core u_dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        if (rst_n && result_strobe)
            sb.check_result(result_value, saturated, coord_error);

    task automatic send(op_t op, int oc, int ic, int r, int c, int tr, int tc, int v);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1;
        operation <= op; out_chan <= 4'(oc); in_chan <= 4'(ic); row <= 5'(r); col <= 5'(c);
        tap_row <= 3'(tr); tap_col <= 3'(tc); value <= 16'(v);
        do @(posedge clk); while (busy);
        sb.note_item(op, oc & 15, ic & 15, r & 31, c & 31, tr & 7, tc & 7, 16'(v));
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int d);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= 6'(d);
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, 6'(d));
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic setup(int nic, int noc, int kr, int kc, int s, int p, int h, int w);
        drain();
        write_reg(REG_IN_CH, nic); write_reg(REG_OUT_CH, noc);
        write_reg(REG_K_ROWS, kr); write_reg(REG_K_COLS, kc);
        write_reg(REG_STEP, s); write_reg(REG_PAD, p);
        write_reg(REG_IN_H, h); write_reg(REG_IN_W, w);
    endtask

    // fill every store entry the current setting can read
    task automatic load_all(int nic, int noc, int kr, int kc, int h, int w, bit extreme);
        for (int o = 0; o < noc && o < 16; o++)
        begin
            send(OP_BIAS, o, $urandom, 0, 0, 0, 0, extreme ? 16'h7fff : $urandom);
            for (int i = 0; i < nic && i < 16; i++)
                for (int a = 0; a < kr && a < 7; a++)
                    for (int b = 0; b < kc && b < 7; b++)
                        send(OP_WEIGHT, o, i, $urandom, $urandom, a, b,
                             extreme ? 16'h8000 : $urandom);
        end
        for (int i = 0; i < nic && i < 16; i++)
            for (int y = 0; y < h && y < 32; y++)
                for (int x = 0; x < w && x < 32; x++)
                    send(OP_PIXEL, $urandom, i, y, x, $urandom, $urandom,
                         extreme ? 16'h8000 : $urandom);
    endtask

    task automatic rand_item(int nic);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            send(OP_WEIGHT, $urandom, $urandom_range(0, nic - 1), $urandom, $urandom,
                 $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
        else if (k == 1)
            send(OP_BIAS, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (k == 2)
            send(OP_PIXEL, $urandom, $urandom_range(0, nic - 1), $urandom, $urandom,
                 $urandom, $urandom, $urandom);
        else
            send(OP_COMPUTE, $urandom, $urandom, $urandom_range(0, k > 7 ? 31 : 7),
                 $urandom_range(0, k > 7 ? 31 : 7), $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int nic, noc, kr, kc, h, w;
        sb = new();
        sb.init();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: small image, extreme values, saturation, padding, bad coordinates
        setup(2, 2, 3, 3, 1, 1, 4, 4);
        load_all(2, 2, 3, 3, 4, 4, 1);
        send(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
        send(OP_COMPUTE, 1, 0, 3, 3, 0, 0, 0);
        send(OP_COMPUTE, 2, 0, 0, 0, 0, 0, 0);
        send(OP_COMPUTE, 0, 0, 4, 0, 0, 0, 0);
        send(OP_COMPUTE, 15, 15, 31, 31, 7, 7, 16'hffff);
        send(OP_WEIGHT, 15, 15, 31, 31, 7, 7, 16'h1234);
        setup(0, 0, 0, 0, 0, 0, 0, 0);
        send(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
        // oversized height and width clamp to 32, stride 7
        setup(1, 1, 2, 2, 7, 0, 63, 63);
        send(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
        send(OP_COMPUTE, 0, 0, 0, 5, 0, 0, 0);
        send(OP_COMPUTE, 0, 0, 5, 0, 0, 0, 0);
        setup(0, 1, 0, 0, 1, 0, 4, 4);
        send(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
        setup(1, 1, 7, 7, 1, 0, 4, 4);
        send(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 8; phase++)
        begin
            nic = (phase == 7) ? 16 : $urandom_range(1, 3);
            noc = $urandom_range(1, phase == 7 ? 2 : 4);
            kr = $urandom_range(1, phase == 7 ? 3 : 7);
            kc = $urandom_range(1, phase == 7 ? 3 : 7);
            h = $urandom_range(1, phase == 7 ? 4 : 8);
            w = $urandom_range(1, phase == 7 ? 4 : 8);
            quiet = (phase == 7);
            setup(phase == 7 ? $urandom_range(16, 31) : nic, noc, kr, kc,
                  $urandom_range(0, 7), $urandom_range(0, 3), h, w);
            load_all(nic, noc, kr, kc, h, w, 0);
            for (int n = 0; n < 50; n++)
            begin
                rand_item(nic);
                if (n == 25) drain();
            end
        end
        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
